// ----- rtl/lac_pkg.sv -----
// Shared types and constants for the layer alpha compositor.
package lac_pkg;

    // Number of layer fields carried by every item.
    localparam int MAX_LAYERS      = 4;
    // Default number of layer cells built into the chain.
    localparam int LAYER_COUNT_DEF = 4;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int LAYERS_W   = 3;
    localparam logic [LAYERS_W-1:0] LAYERS_RESET = 3'd4;

    // Alpha value of a fully opaque layer.
    localparam logic [7:0] FULL_ALPHA = 8'hff;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BG_RED   = 2'd0,
        REG_BG_GREEN = 2'd1,
        REG_BG_BLUE  = 2'd2,
        REG_LAYERS   = 2'd3
    } t_cfg_reg;

    // One packed layer pixel: R, G, B, alpha from high to low byte.
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } t_pixel;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    // What one cell hands to the next: the running color and the layer pixels.
    typedef struct packed {
        logic                         valid;
        logic                         covered;
        t_rgb                         color;
        t_pixel [MAX_LAYERS-1:0]      pixels;
    } t_stage;

endpackage

// ----- rtl/lac_in_if.sv -----
// Input channel interface: four layer pixels per transfer.
interface lac_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] layer0_pixel;
    logic [31:0] layer1_pixel;
    logic [31:0] layer2_pixel;
    logic [31:0] layer3_pixel;

    modport source (
        output valid, layer0_pixel, layer1_pixel, layer2_pixel, layer3_pixel,
        input  ready
    );

    modport sink (
        input  valid, layer0_pixel, layer1_pixel, layer2_pixel, layer3_pixel,
        output ready
    );
endinterface

// ----- rtl/lac_out_if.sv -----
// Output channel interface: one composited pixel per transfer.
interface lac_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       covered;

    modport source (
        output valid, out_red, out_green, out_blue, covered,
        input  ready
    );

    modport sink (
        input  valid, out_red, out_green, out_blue, covered,
        output ready
    );
endinterface

// ----- rtl/lac_cell.sv -----
// One compositing cell: blends its own layer over the running color and registers it.
module lac_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [lac_pkg::LAYERS_W-1:0]  i_layers,
    input  lac_pkg::t_stage               i_up,
    output logic                          o_up_ready,
    output lac_pkg::t_stage               o_dn,
    input  logic                          i_dn_ready
);
    import lac_pkg::*;

    // floor((p*a + c*(255-a)) / 255); the sum never exceeds 65025, so the
    // reciprocal form (x + 1 + (x >> 8)) >> 8 is exact and fits 16 bits.
    function automatic logic [7:0] mix_channel(
        input logic [7:0] p,
        input logic [7:0] c,
        input logic [7:0] a
    );
        logic [15:0] sum;
        logic [15:0] adj;
        sum = 16'(p) * 16'(a) + 16'(c) * 16'(FULL_ALPHA - a);
        adj = sum + 16'd1 + {8'd0, sum[15:8]};
        return adj[15:8];
    endfunction

    logic   r_valid;
    t_stage r_stage;
    t_stage n_stage;
    t_pixel w_px;
    logic   w_layer_on;

    // This cell holds a layer only when its index lies below the count in use.
    assign w_layer_on = (i_layers > LAYERS_W'(CELL_IDX));
    assign w_px       = i_up.pixels[CELL_IDX];

    // Blend the cell's layer into the running color.
    always_comb begin
        n_stage = i_up;
        if (w_layer_on && (w_px.a != 8'd0)) begin
            n_stage.covered = 1'b1;
            if (w_px.a == FULL_ALPHA) begin
                n_stage.color.r = w_px.r;
                n_stage.color.g = w_px.g;
                n_stage.color.b = w_px.b;
            end else begin
                n_stage.color.r = mix_channel(w_px.r, i_up.color.r, w_px.a);
                n_stage.color.g = mix_channel(w_px.g, i_up.color.g, w_px.a);
                n_stage.color.b = mix_channel(w_px.b, i_up.color.b, w_px.a);
            end
        end
    end

    // The cell takes a new item when it is empty or its content moves on.
    assign o_up_ready = !r_valid || i_dn_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_valid <= i_up.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_up_ready && i_up.valid) begin
            r_stage <= n_stage;
        end
    end

    always_comb begin
        o_dn       = r_stage;
        o_dn.valid = r_valid;
    end

endmodule

// ----- rtl/layer_alpha_compositor.sv -----
// Top level of the layer alpha compositor: configuration registers and the cell chain.
//
// Usage:
// Each transfer on i_pix carries one screen pixel as four packed RGBA words,
// bottom layer first. Each transfer on o_pix returns the composited color and
// a covered flag that is set when any layer in use had nonzero alpha.
// The configuration port writes the background red, green and blue and the
// number of bottom layers in use; the user must see that it is written only
// while the block is idle, which the block itself does not enforce. The block is
// a chain of LAYER_COUNT cells, one per layer; every pixel passes in turn through
// each cell's register, and one pixel is accepted every cycle while output is taken.
// Each cell moves its item on when the next cell is empty or moving, so a
// stalled receiver fills the chain from the output end; input ready falls only
// when every cell holds an item. Up to LAYER_COUNT pixels are held in flight.
// Reset empties the chain, sets the background to black and the layer count
// to four.
module layer_alpha_compositor #(
    parameter int LAYER_COUNT = lac_pkg::LAYER_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lac_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lac_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    lac_in_if.sink                          i_pix,
    lac_out_if.source                       o_pix
);
    import lac_pkg::*;

    logic [7:0]          r_bg_red;
    logic [7:0]          r_bg_green;
    logic [7:0]          r_bg_blue;
    logic [LAYERS_W-1:0] r_layers;

    t_stage w_link [0:LAYER_COUNT];
    logic   w_rdy  [0:LAYER_COUNT];

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg_red   <= 8'd0;
            r_bg_green <= 8'd0;
            r_bg_blue  <= 8'd0;
            r_layers   <= LAYERS_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_BG_RED:   r_bg_red   <= i_cfg_data;
                REG_BG_GREEN: r_bg_green <= i_cfg_data;
                REG_BG_BLUE:  r_bg_blue  <= i_cfg_data;
                REG_LAYERS:   r_layers   <= i_cfg_data[LAYERS_W-1:0];
                default:      r_layers   <= r_layers;
            endcase
        end
    end

    // Head of the chain: the background color under all layers.
    always_comb begin
        w_link[0].valid     = i_pix.valid;
        w_link[0].covered   = 1'b0;
        w_link[0].color.r   = r_bg_red;
        w_link[0].color.g   = r_bg_green;
        w_link[0].color.b   = r_bg_blue;
        w_link[0].pixels[0] = t_pixel'(i_pix.layer0_pixel);
        w_link[0].pixels[1] = t_pixel'(i_pix.layer1_pixel);
        w_link[0].pixels[2] = t_pixel'(i_pix.layer2_pixel);
        w_link[0].pixels[3] = t_pixel'(i_pix.layer3_pixel);
    end

    assign i_pix.ready = w_rdy[0];

    // One cell per layer, bottom layer first.
    for (genvar k = 0; k < LAYER_COUNT; k++) begin : g_cell
        lac_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_layers   (r_layers),
            .i_up       (w_link[k]),
            .o_up_ready (w_rdy[k]),
            .o_dn       (w_link[k+1]),
            .i_dn_ready (w_rdy[k+1])
        );
    end

    // Tail of the chain drives the output channel.
    assign w_rdy[LAYER_COUNT] = o_pix.ready;
    assign o_pix.valid        = w_link[LAYER_COUNT].valid;
    assign o_pix.out_red      = w_link[LAYER_COUNT].color.r;
    assign o_pix.out_green    = w_link[LAYER_COUNT].color.g;
    assign o_pix.out_blue     = w_link[LAYER_COUNT].color.b;
    assign o_pix.covered      = w_link[LAYER_COUNT].covered;

endmodule

// ----- rtl/lac_checker.sv -----
// Port-level assertions for the layer alpha compositor, bound to the top level.
module lac_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_cfg_we,
    input logic [lac_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input logic [lac_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [7:0]                      i_out_red,
    input logic [7:0]                      i_out_green,
    input logic [7:0]                      i_out_blue,
    input logic                            i_out_covered
);
    import lac_pkg::*;

    logic [7:0]          r_bg_red;
    logic [7:0]          r_bg_green;
    logic [7:0]          r_bg_blue;
    logic [LAYERS_W-1:0] r_layers;

    // Shadow copy of the configuration, tracked from the write port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg_red   <= 8'd0;
            r_bg_green <= 8'd0;
            r_bg_blue  <= 8'd0;
            r_layers   <= LAYERS_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_BG_RED:   r_bg_red   <= i_cfg_data;
                REG_BG_GREEN: r_bg_green <= i_cfg_data;
                REG_BG_BLUE:  r_bg_blue  <= i_cfg_data;
                REG_LAYERS:   r_layers   <= i_cfg_data[LAYERS_W-1:0];
                default:      r_layers   <= r_layers;
            endcase
        end
    end

    // Reset empties the chain.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // An empty output stage means every cell can take an item.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input not ready while output stage is empty");

    // An uncovered pixel shows the background color.
    a_uncovered_bg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_covered) |->
        (i_out_red == r_bg_red && i_out_green == r_bg_green && i_out_blue == r_bg_blue))
        else $error("uncovered pixel differs from background");

    // With no layer in use nothing can cover the pixel.
    a_no_layers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && r_layers == '0) |-> !i_out_covered)
        else $error("covered set with no layers in use");

    // A stalled result holds until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_red) && $stable(i_out_green)
         && $stable(i_out_blue) && $stable(i_out_covered)))
        else $error("stalled output changed");

endmodule

bind layer_alpha_compositor lac_checker u_lac_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_idx     (i_cfg_idx),
    .i_cfg_data    (i_cfg_data),
    .i_in_ready    (i_pix.ready),
    .i_out_valid   (o_pix.valid),
    .i_out_ready   (o_pix.ready),
    .i_out_red     (o_pix.out_red),
    .i_out_green   (o_pix.out_green),
    .i_out_blue    (o_pix.out_blue),
    .i_out_covered (o_pix.covered)
);
